FILE: sv/smx_pkg.sv
package smx_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [3:0] {
    OP_LD  = 4'd0,
    OP_ST  = 4'd1,
    OP_LDC = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_CMP = 4'd5,
    OP_JMP = 4'd6,
    OP_BR  = 4'd7,
    OP_RET = 4'd8
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RET   = 3'd1,
    ST_UNDER = 3'd2,
    ST_LABEL = 3'd3,
    ST_OVER  = 3'd4,
    ST_ADDR  = 3'd5
  } status_e;

  // per-cell load select; "prev" is the cell nearer the top
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_PREV,
    CELL_LOAD_NEXT,
    CELL_LOAD_NEXT2
  } cell_op_e;

  typedef struct packed {
    cell_op_e            head_op;
    cell_op_e            body_op;
    logic [WORD_W-1:0]   push_data;
  } stk_ctrl_t;

endpackage

FILE: sv/stack_machine_execute_unit.sv
// Stack-machine execute unit.
// A request is registered in the request stage and its result in the result
// register; a stalled result holds the stage. Throughput: one request per
// cycle while no result stalls; the operand stack is a shift row of cells
// with top and next always visible, and ld data is read at accept time.
// Reset: index, depth, halt and error state and handshake valids clear;
// stack cells and data memory hold no reset value until written.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH   = 256,
  parameter int unsigned DATA_DEPTH    = 4096,
  parameter int unsigned PROGRAM_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic signed [31:0] operand_i,
  input  logic [11:0] target_index_i,
  input  logic        label_found_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] next_index_o,
  output logic signed [31:0] top_value_o,
  output logic [8:0]  stack_count_o,
  output logic [2:0]  status_o
);
  import smx_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = $clog2(DATA_DEPTH);
  localparam int unsigned PW = $clog2(PROGRAM_DEPTH);
  localparam logic [31:0] DataDepth32 = 32'(DATA_DEPTH);
  localparam logic [31:0] ProgDepth32 = 32'(PROGRAM_DEPTH);
  localparam logic [CW-1:0] StackFull = CW'(STACK_DEPTH);
  localparam logic [PW-1:0] LastIndex = PW'(PROGRAM_DEPTH - 1);

  // ---------------------------------------------------------------
  // Handshake: one request stage, one result register
  // ---------------------------------------------------------------
  logic in_fire, exec_fire;
  logic s1_valid_q, out_valid_q;

  assign exec_fire  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || exec_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // request stage payload
  logic [3:0]        act_q;
  logic [31:0]       opnd_q;
  logic [11:0]       tgt_q;
  logic              found_q;
  logic [WORD_W-1:0] rd_q;

  // architectural state
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] pc_q;
  logic          halted_q;
  status_e       err_q;

  // ---------------------------------------------------------------
  // Operand stack (row of cells)
  // ---------------------------------------------------------------
  stk_ctrl_t         stk_ctrl;
  logic [WORD_W-1:0] top_v, second_v;

  smx_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .ctrl_i   (stk_ctrl),
    .top_o    (top_v),
    .second_o (second_v)
  );

  // ---------------------------------------------------------------
  // Data memory; read at accept, write-first bypass for a st
  // finishing on the same edge
  // ---------------------------------------------------------------
  logic [WORD_W-1:0] dmem [DATA_DEPTH];
  logic              wr_c, wr_en;
  logic [DW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;

  assign wr_en   = exec_fire && wr_c;
  assign wr_addr = opnd_q[DW-1:0];
  assign wr_data = top_v;
  assign rd_addr = operand_i[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dmem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= dmem[rd_addr];
      end
    end
  end

  // ---------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------
  status_e           status_c;
  logic              jump_c, fault_c, freeze_c;
  logic [CW-1:0]     cnt_c, cnt_d;
  logic [PW-1:0]     pc_adv, pc_d;
  logic              room, ge2, empty, addr_ok, tgt_ok;
  cell_op_e          head_c, body_c;
  logic [WORD_W-1:0] push_c, top_after;
  logic [31:0]       pc_wide, cnt_wide;

  assign room    = cnt_q < StackFull;
  assign ge2     = cnt_q >= CW'(2);
  assign empty   = cnt_q == '0;
  assign addr_ok = !opnd_q[31] && (opnd_q < DataDepth32);
  assign tgt_ok  = found_q && (32'(tgt_q) < ProgDepth32);
  assign pc_adv  = (pc_q == LastIndex) ? '0 : pc_q + PW'(1);

  always_comb begin
    status_c = ST_OK;
    jump_c   = 1'b0;
    wr_c     = 1'b0;
    head_c   = CELL_HOLD;
    body_c   = CELL_HOLD;
    push_c   = opnd_q;
    cnt_c    = cnt_q;
    unique case (opcode_e'(act_q))
      OP_LD: begin
        if (!addr_ok) begin
          status_c = ST_ADDR;
        end else if (!room) begin
          status_c = ST_OVER;
        end else begin
          push_c = rd_q;
          head_c = CELL_LOAD_PREV;
          body_c = CELL_LOAD_PREV;
          cnt_c  = cnt_q + CW'(1);
        end
      end
      OP_ST: begin
        if (empty) begin
          status_c = ST_UNDER;
        end else if (!addr_ok) begin
          status_c = ST_ADDR;
        end else begin
          wr_c   = 1'b1;
          head_c = CELL_LOAD_NEXT;
          body_c = CELL_LOAD_NEXT;
          cnt_c  = cnt_q - CW'(1);
        end
      end
      OP_LDC: begin
        if (!room) begin
          status_c = ST_OVER;
        end else begin
          head_c = CELL_LOAD_PREV;
          body_c = CELL_LOAD_PREV;
          cnt_c  = cnt_q + CW'(1);
        end
      end
      OP_ADD, OP_SUB: begin
        if (!ge2) begin
          status_c = ST_UNDER;
        end else begin
          // top op next, result replaces both; the rest moves up one
          push_c = (opcode_e'(act_q) == OP_ADD) ? top_v + second_v : top_v - second_v;
          head_c = CELL_LOAD_PREV;
          body_c = CELL_LOAD_NEXT;
          cnt_c  = cnt_q - CW'(1);
        end
      end
      OP_CMP: begin
        if (!ge2) begin
          status_c = ST_UNDER;
        end else if (!room) begin
          status_c = ST_OVER;
        end else begin
          if ($signed(top_v) > $signed(second_v)) begin
            push_c = WORD_W'(1);
          end else if (top_v == second_v) begin
            push_c = '0;
          end else begin
            push_c = '1;
          end
          head_c = CELL_LOAD_PREV;
          body_c = CELL_LOAD_PREV;
          cnt_c  = cnt_q + CW'(1);
        end
      end
      OP_JMP: begin
        if (!tgt_ok) begin
          status_c = ST_LABEL;
        end else begin
          jump_c = 1'b1;
        end
      end
      OP_BR: begin
        if (empty) begin
          status_c = ST_UNDER;
        end else if (top_v != '0) begin
          if (!tgt_ok) begin
            status_c = ST_LABEL;
          end else begin
            jump_c = 1'b1;
          end
        end
      end
      OP_RET: begin
        status_c = ST_RET;
      end
      default: begin
        // undefined opcodes just advance
      end
    endcase

    fault_c  = !halted_q && (status_c != ST_OK);
    freeze_c = halted_q || (status_c != ST_OK);

    if (freeze_c) begin
      wr_c   = 1'b0;
      head_c = CELL_HOLD;
      body_c = CELL_HOLD;
      cnt_c  = cnt_q;
      pc_d   = pc_q;
    end else if (jump_c) begin
      pc_d = PW'(tgt_q);
    end else begin
      pc_d = pc_adv;
    end

    cnt_d = cnt_c;

    // top of stack as it will look after this step
    unique case (head_c)
      CELL_LOAD_PREV: top_after = push_c;
      CELL_LOAD_NEXT: top_after = (cnt_c != '0) ? second_v : '0;
      default:        top_after = empty ? '0 : top_v;
    endcase

    stk_ctrl.head_op   = exec_fire ? head_c : CELL_HOLD;
    stk_ctrl.body_op   = exec_fire ? body_c : CELL_HOLD;
    stk_ctrl.push_data = push_c;
  end

  assign pc_wide  = 32'(pc_d);
  assign cnt_wide = 32'(cnt_d);

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      err_q       <= ST_OK;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (exec_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        cnt_q <= cnt_d;
        pc_q  <= pc_d;
        if (fault_c) begin
          halted_q <= 1'b1;
          err_q    <= status_c;
        end
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= action_i;
      opnd_q  <= operand_i;
      tgt_q   <= target_index_i;
      found_q <= label_found_i;
    end
    if (exec_fire) begin
      next_index_o  <= pc_wide[11:0];
      top_value_o   <= top_after;
      stack_count_o <= cnt_wide[8:0];
      status_o      <= halted_q ? err_q : status_c;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/smx_cell.sv
module smx_cell (
  input  logic                    clk_i,
  input  smx_pkg::cell_op_e       op_i,
  input  logic [smx_pkg::WORD_W-1:0] prev_i,
  input  logic [smx_pkg::WORD_W-1:0] next_i,
  input  logic [smx_pkg::WORD_W-1:0] next2_i,
  output logic [smx_pkg::WORD_W-1:0] value_o
);
  import smx_pkg::*;

  logic [WORD_W-1:0] value_q, value_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:       value_d = value_q;
      CELL_LOAD_PREV:  value_d = prev_i;
      CELL_LOAD_NEXT:  value_d = next_i;
      CELL_LOAD_NEXT2: value_d = next2_i;
      default:         value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: sv/smx_stack.sv
module smx_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  smx_pkg::stk_ctrl_t         ctrl_i,
  output logic [smx_pkg::WORD_W-1:0] top_o,
  output logic [smx_pkg::WORD_W-1:0] second_o
);
  import smx_pkg::*;

  // cell 0 is the top of stack; two zero taps past the bottom
  logic [WORD_W-1:0] val [DEPTH+2];

  assign val[DEPTH]   = '0;
  assign val[DEPTH+1] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      smx_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.head_op),
        .prev_i  (ctrl_i.push_data),
        .next_i  (val[i+1]),
        .next2_i (val[i+2]),
        .value_o (val[i])
      );
    end else begin : g_body
      smx_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.body_op),
        .prev_i  (val[i-1]),
        .next_i  (val[i+1]),
        .next2_i (val[i+2]),
        .value_o (val[i])
      );
    end
  end

  assign top_o    = val[0];
  assign second_o = val[1];

endmodule

FILE: verif/tb_stack_machine_execute_unit.sv
module tb_stack_machine_execute_unit;
  import smx_pkg::*;

  // Sizes the block is built with here; the predictor uses the same ones.
  localparam int STACK_WORDS   = 256;
  localparam int DATA_WORDS    = 4096;
  localparam int PROGRAM_WORDS = 4096;

  // Opcodes above ret are spare and act as no-ops.
  localparam int FIRST_SPARE_OP = int'(OP_RET) + 1;
  localparam int LAST_SPARE_OP  = 15;

  localparam int ITEMS_PER_PHASE = 583;
  localparam int HALTED_ITEMS    = 6;
  localparam int TAIL_CYCLES     = 8;
  localparam int CYCLE_LIMIT     = 400000;

  // How the run ends: each kind halts the block in its own way.
  typedef enum int {
    FK_RET,
    FK_LD_NEG_ADDR,
    FK_LD_ADDR_FULL,    // address is checked before room
    FK_ST_EMPTY_BAD,    // empty stack is checked before the address
    FK_ST_BAD_ADDR,
    FK_ADD_SHORT,
    FK_SUB_EMPTY,
    FK_CMP_SHORT,
    FK_CMP_FULL,
    FK_LDC_FULL,
    FK_LD_FULL,
    FK_JMP_NOLABEL,
    FK_BR_NOLABEL,
    FK_BR_EMPTY,
    FK_COUNT
  } fault_kind_e;

  typedef struct {
    logic [3:0]         action;
    logic signed [31:0] operand;
    logic [11:0]        target;
    logic               label_found;
  } request_t;

  typedef struct {
    logic [11:0]        next_index;
    logic signed [31:0] top;
    logic [8:0]         count;
    logic [2:0]         status;
  } result_t;

  // Executes each accepted request on its own copy of the machine state and
  // checks the block's results in order against what it worked out.
  class exec_checker;
    logic [31:0] stack_word [STACK_WORDS];
    logic [31:0] data_word [DATA_WORDS];
    bit          written [DATA_WORDS];
    int          written_addrs [$];
    int unsigned depth;
    int unsigned max_depth;
    logic [11:0] pc;
    bit          halted;
    status_e     err;
    result_t     pending_results [$];
    int unsigned accepted;
    int unsigned checked;
    int unsigned failures;

    function new();
      depth     = 0;
      max_depth = 0;
      pc        = '0;
      halted    = 1'b0;
      err       = ST_OK;
      accepted  = 0;
      checked   = 0;
      failures  = 0;
    endfunction

    function logic [31:0] top_word();
      return (depth != 0) ? stack_word[depth-1] : 32'd0;
    endfunction

    function bit addr_ok(logic signed [31:0] a);
      return (a >= 0) && (a < DATA_WORDS);
    endfunction

    function bit label_ok(request_t r);
      return r.label_found && (int'(r.target) < PROGRAM_WORDS);
    endfunction

    // Status a request gets on a running machine; nothing is changed.
    function status_e fault_of(request_t r);
      logic room;
      room = (depth < STACK_WORDS);
      case (r.action)
        OP_LD: begin
          if (!addr_ok(r.operand)) return ST_ADDR;
          else if (!room) return ST_OVER;
        end
        OP_ST: begin
          if (depth == 0) return ST_UNDER;
          else if (!addr_ok(r.operand)) return ST_ADDR;
        end
        OP_LDC: if (!room) return ST_OVER;
        OP_ADD, OP_SUB: if (depth < 2) return ST_UNDER;
        OP_CMP: begin
          if (depth < 2) return ST_UNDER;
          else if (!room) return ST_OVER;
        end
        OP_JMP: if (!label_ok(r)) return ST_LABEL;
        OP_BR: begin
          if (depth == 0) return ST_UNDER;
          else if (top_word() != 0 && !label_ok(r)) return ST_LABEL;
        end
        OP_RET: return ST_RET;
        default: ;
      endcase
      return ST_OK;
    endfunction

    function void push(logic [31:0] v);
      stack_word[depth] = v;
      depth++;
      if (depth > max_depth) max_depth = depth;
    endfunction

    function logic [31:0] pop();
      depth--;
      return stack_word[depth];
    endfunction

    function void record_instr(request_t r);
      result_t     res;
      status_e     st;
      logic [11:0] nxt;
      logic [31:0] a;
      logic [31:0] b;
      int          idx;
      accepted++;
      nxt = (int'(pc) + 1 >= PROGRAM_WORDS) ? 12'd0 : pc + 12'd1;
      if (halted) begin
        st  = err;
        nxt = pc;
      end else begin
        st = fault_of(r);
        if (st == ST_OK) begin
          idx = int'(r.operand);
          case (r.action)
            OP_LD:  push(data_word[idx]);
            OP_ST: begin
              data_word[idx] = pop();
              if (!written[idx]) written_addrs.push_back(idx);
              written[idx] = 1'b1;
            end
            OP_LDC: push(r.operand);
            OP_ADD: begin
              a = pop();
              b = pop();
              push(a + b);
            end
            OP_SUB: begin
              a = pop();
              b = pop();
              push(a - b);
            end
            OP_CMP: begin
              // both operands stay; the sign of top minus next goes on top
              a = stack_word[depth-1];
              b = stack_word[depth-2];
              if ($signed(a) > $signed(b)) push(32'd1);
              else if (a == b) push(32'd0);
              else push(32'hFFFF_FFFF);
            end
            OP_JMP: nxt = r.target;
            OP_BR:  if (top_word() != 0) nxt = r.target;
            default: ;
          endcase
          pc = nxt;
        end else begin
          // faults leave stack, memory and index untouched
          halted = 1'b1;
          err    = st;
          nxt    = pc;
        end
      end
      res.next_index = nxt;
      res.top        = top_word();
      res.count      = 9'(depth);
      res.status     = st;
      pending_results.push_back(res);
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: next_index %0d status %0d",
               seen.next_index, seen.status);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (seen.next_index !== want.next_index) begin
        $error("next_index: expected %0d, got %0d", want.next_index, seen.next_index);
        failures++;
      end
      if (seen.top !== want.top) begin
        $error("top_value: expected %0d, got %0d", want.top, seen.top);
        failures++;
      end
      if (seen.count !== want.count) begin
        $error("stack_count: expected %0d, got %0d", want.count, seen.count);
        failures++;
      end
      if (seen.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, seen.status);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [3:0]         action_i       = '0;
  logic signed [31:0] operand_i      = '0;
  logic [11:0]        target_index_i = '0;
  logic               label_found_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [11:0]        next_index_o;
  logic signed [31:0] top_value_o;
  logic [8:0]         stack_count_o;
  logic [2:0]         status_o;

  exec_checker sb;
  int          send_idle_pct = 0;   // chance in 100 that the sender skips a cycle
  int          recv_idle_pct = 0;   // chance in 100 that the receiver stalls
  int unsigned cycle_count   = 0;
  fault_kind_e last_fault;

  stack_machine_execute_unit #(
    .STACK_DEPTH   (STACK_WORDS),
    .DATA_DEPTH    (DATA_WORDS),
    .PROGRAM_DEPTH (PROGRAM_WORDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .operand_i      (operand_i),
    .target_index_i (target_index_i),
    .label_found_i  (label_found_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_index_o   (next_index_o),
    .top_value_o    (top_value_o),
    .stack_count_o  (stack_count_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on total run time.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check on handshake, then pick next cycle's ready.
  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (out_valid_o && out_ready_i) begin
      seen.next_index = next_index_o;
      seen.top        = top_value_o;
      seen.count      = stack_count_o;
      seen.status     = status_o;
      sb.check_result(seen);
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Holds one request on the bus until it is taken. Valid only drops in an
  // idle gap, so back-to-back requests keep it high across the edge.
  task automatic send_instr(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= r.action;
    operand_i      <= r.operand;
    target_index_i <= r.target;
    label_found_i  <= r.label_found;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.record_instr(r);
  endtask

  task automatic issue(logic [3:0] act, logic signed [31:0] opnd, logic [11:0] tgt,
                       logic found);
    request_t r;
    r.action      = act;
    r.operand     = opnd;
    r.target      = tgt;
    r.label_found = found;
    send_instr(r);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random request with random content; push_pct steers the stack depth.
  // The caller filters out anything that would fault.
  function automatic request_t random_instr(int push_pct);
    request_t r;
    r.operand     = $urandom;
    r.target      = 12'($urandom);
    r.label_found = 1'($urandom);
    if ($urandom_range(99) < push_pct) begin
      if (sb.written_addrs.size() != 0 && $urandom_range(2) == 0) begin
        // ld only from words already stored
        r.action  = OP_LD;
        r.operand = sb.written_addrs[$urandom_range(sb.written_addrs.size() - 1)];
      end else begin
        r.action = OP_LDC;
        case ($urandom_range(7))
          0: r.operand = 32'sh7FFF_FFFF;
          1: r.operand = 32'sh8000_0000;
          2: r.operand = 32'sh0;
          3: r.operand = -32'sd1;
          4: r.operand = $urandom_range(3);   // small values make cmp ties
          default: ;
        endcase
      end
    end else begin
      case ($urandom_range(7))
        0, 1: begin
          r.action  = OP_ST;
          r.operand = $urandom_range(1) ? $urandom_range(63) : $urandom_range(DATA_WORDS - 1);
        end
        2: r.action = OP_ADD;
        3: r.action = OP_SUB;
        4: r.action = OP_CMP;
        5: begin
          r.action      = OP_JMP;
          r.label_found = 1'b1;
        end
        6: begin
          // not-taken branches may carry a missing label
          r.action = OP_BR;
          if (sb.top_word() != 0) r.label_found = 1'b1;
        end
        default: r.action = 4'($urandom_range(LAST_SPARE_OP, FIRST_SPARE_OP));
      endcase
    end
    return r;
  endfunction

  task automatic send_legal(int push_pct);
    request_t r;
    do r = random_instr(push_pct); while (sb.fault_of(r) != ST_OK);
    send_instr(r);
  endtask

  // Pushes constants or pops into memory until the stack holds n words.
  task automatic settle_depth(int unsigned n);
    while (sb.depth < n) issue(OP_LDC, $urandom, 12'($urandom), 1'($urandom));
    while (sb.depth > n) issue(OP_ST, $urandom_range(DATA_WORDS - 1), 12'($urandom),
                               1'($urandom));
  endtask

  // Short directed program: extremes, every opcode but ret, wraps and cmp outcomes.
  task automatic run_directed();
    issue(OP_LDC, 32'sh7FFF_FFFF, 12'h000, 1'b0);
    issue(OP_LDC, 32'sh8000_0000, 12'hFFF, 1'b1);
    issue(OP_CMP, 32'sh0, 12'h000, 1'b0);          // min vs max: less
    issue(OP_ADD, 32'sh0, 12'h000, 1'b0);          // -1 + min wraps
    issue(OP_SUB, 32'sh0, 12'h000, 1'b0);          // top minus next = 0
    issue(OP_BR, 32'sh0, 12'hFFF, 1'b0);           // top zero: label ignored
    issue(OP_ST, DATA_WORDS - 1, 12'h000, 1'b0);   // highest address
    issue(OP_LDC, -32'sd1, 12'h000, 1'b0);
    issue(OP_ST, 32'sh0, 12'h000, 1'b0);           // lowest address
    issue(OP_LD, DATA_WORDS - 1, 12'h000, 1'b0);
    issue(OP_LD, 32'sh0, 12'h000, 1'b0);
    issue(OP_CMP, 32'sh0, 12'h000, 1'b0);          // less
    issue(OP_LDC, 32'sh1, 12'h000, 1'b0);
    issue(OP_CMP, 32'sh0, 12'h000, 1'b0);          // greater
    issue(OP_LDC, 32'sh5, 12'h000, 1'b0);
    issue(OP_LDC, 32'sh5, 12'h000, 1'b0);
    issue(OP_CMP, 32'sh0, 12'h000, 1'b0);          // equal
    issue(OP_JMP, 32'sh0, 12'(PROGRAM_WORDS - 1), 1'b1);
    issue(4'(LAST_SPARE_OP), $urandom, 12'($urandom), 1'b1);   // index wraps to 0
    issue(OP_JMP, 32'sh0, 12'(PROGRAM_WORDS - 2), 1'b1);
    issue(4'(FIRST_SPARE_OP), $urandom, 12'($urandom), 1'b0);
    issue(OP_LDC, 32'sh3, 12'h000, 1'b0);
    issue(OP_BR, 32'sh0, 12'h5A3, 1'b1);           // taken
    issue(OP_SUB, 32'sh0, 12'h000, 1'b0);
  endtask

  // Drives the machine into one fault, then checks that it stays halted.
  task automatic end_with_fault(fault_kind_e kind);
    request_t r;
    r.operand     = $urandom;
    r.target      = 12'($urandom);
    r.label_found = 1'($urandom);
    case (kind)
      FK_RET: r.action = OP_RET;
      FK_LD_NEG_ADDR: begin
        r.action  = OP_LD;
        r.operand = r.operand | 32'sh8000_0000;
      end
      FK_LD_ADDR_FULL: begin
        settle_depth(STACK_WORDS);
        r.action  = OP_LD;
        r.operand = DATA_WORDS + $urandom_range(1000);
      end
      FK_ST_EMPTY_BAD: begin
        settle_depth(0);
        r.action  = OP_ST;
        r.operand = -32'sd1;
      end
      FK_ST_BAD_ADDR: begin
        if (sb.depth == 0) settle_depth(1);
        r.action  = OP_ST;
        r.operand = DATA_WORDS;
      end
      FK_ADD_SHORT: begin
        settle_depth(1);
        r.action = OP_ADD;
      end
      FK_SUB_EMPTY: begin
        settle_depth(0);
        r.action = OP_SUB;
      end
      FK_CMP_SHORT: begin
        settle_depth(1);
        r.action = OP_CMP;
      end
      FK_CMP_FULL: begin
        settle_depth(STACK_WORDS);
        r.action = OP_CMP;
      end
      FK_LDC_FULL: begin
        settle_depth(STACK_WORDS);
        r.action = OP_LDC;
      end
      FK_LD_FULL: begin
        // the address is checked before room, so any valid address will do
        settle_depth(STACK_WORDS);
        r.action  = OP_LD;
        r.operand = $urandom_range(DATA_WORDS - 1);
      end
      FK_JMP_NOLABEL: begin
        r.action      = OP_JMP;
        r.label_found = 1'b0;
      end
      FK_BR_NOLABEL: begin
        if (sb.depth == STACK_WORDS) settle_depth(STACK_WORDS - 1);
        issue(OP_LDC, 32'sh7, 12'h000, 1'b0);
        r.action      = OP_BR;
        r.label_found = 1'b0;
      end
      default: begin
        settle_depth(0);
        r.action = OP_BR;
      end
    endcase
    send_instr(r);
    // anything after the fault must leave the machine as it is
    repeat (HALTED_ITEMS) issue(4'($urandom), $urandom, 12'($urandom), 1'($urandom));
  endtask

  initial begin
    int push_pct;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 67;
    run_directed();

    // three traffic phases: slow receiver, slow sender, full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      push_pct = 50;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 100 == 0) push_pct = $urandom_range(75, 25);
        // second phase climbs to a full stack and stays near it a while
        if (phase == 1 && i < 350) push_pct = 96;
        send_legal(push_pct);
      end
      hold_until_drained();
    end

    last_fault = fault_kind_e'($urandom_range(int'(FK_COUNT) - 1));
    end_with_fault(last_fault);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run: %0d requests, %0d results checked, deepest stack %0d words",
             sb.accepted, sb.checked, sb.max_depth);
    $display("run: halted by %s, %0d mismatches", last_fault.name(), sb.failures);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: stack_machine_execute_unit.f
sv/smx_pkg.sv
sv/smx_cell.sv
sv/smx_stack.sv
sv/stack_machine_execute_unit.sv
verif/tb_stack_machine_execute_unit.sv
